### hw/rtl/md5_pkg.sv
package md5_pkg;

  typedef enum logic [1:0] {
    CMD_ABSORB  = 2'd0,
    CMD_FINISH  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_part;
    logic        part_index;
    logic        last;
  } out_item_t;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_OUT0,
    ST_OUT1
  } state_t;

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] r;
    r = 5'd0;
    unique case ({i[5:4], i[1:0]})
      4'b0000: r = 5'd7;
      4'b0001: r = 5'd12;
      4'b0010: r = 5'd17;
      4'b0011: r = 5'd22;
      4'b0100: r = 5'd5;
      4'b0101: r = 5'd9;
      4'b0110: r = 5'd14;
      4'b0111: r = 5'd20;
      4'b1000: r = 5'd4;
      4'b1001: r = 5'd11;
      4'b1010: r = 5'd16;
      4'b1011: r = 5'd23;
      4'b1100: r = 5'd6;
      4'b1101: r = 5'd10;
      4'b1110: r = 5'd15;
      default: r = 5'd21;
    endcase
    return r;
  endfunction

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478,32'he8c7b756,32'h242070db,32'hc1bdceee,32'hf57c0faf,32'h4787c62a,
    32'ha8304613,32'hfd469501,32'h698098d8,32'h8b44f7af,32'hffff5bb1,32'h895cd7be,
    32'h6b901122,32'hfd987193,32'ha679438e,32'h49b40821,32'hf61e2562,32'hc040b340,
    32'h265e5a51,32'he9b6c7aa,32'hd62f105d,32'h02441453,32'hd8a1e681,32'he7d3fbc8,
    32'h21e1cde6,32'hc33707d6,32'hf4d50d87,32'h455a14ed,32'ha9e3e905,32'hfcefa3f8,
    32'h676f02d9,32'h8d2a4c8a,32'hfffa3942,32'h8771f681,32'h6d9d6122,32'hfde5380c,
    32'ha4beea44,32'h4bdecfa9,32'hf6bb4b60,32'hbebfbc70,32'h289b7ec6,32'heaa127fa,
    32'hd4ef3085,32'h04881d05,32'hd9d4d039,32'he6db99e5,32'h1fa27cf8,32'hc4ac5665,
    32'hf4292244,32'h432aff97,32'hab9423a7,32'hfc93a039,32'h655b59c3,32'h8f0ccc92,
    32'hffeff47d,32'h85845dd1,32'h6fa87e4f,32'hfe2ce6e0,32'ha3014314,32'h4e0811a1,
    32'hf7537e82,32'hbd3af235,32'h2ad7d2bb,32'heb86d391
  };

  function automatic logic [3:0] word_sel(input logic [5:0] i);
    logic [3:0] g;
    g = 4'd0;
    unique case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i + 1);
      2'd2: g = 4'(3 * i + 5);
      default: g = 4'(7 * i);
    endcase
    return g;
  endfunction

  function automatic logic [63:0] swap_bytes(input logic [31:0] x, input logic [31:0] y);
    return {x[7:0], x[15:8], x[23:16], x[31:24], y[7:0], y[15:8], y[23:16], y[31:24]};
  endfunction

endpackage

### hw/rtl/md5_front.sv
module md5_front #(
  parameter int DEPTH = md5_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  md5_pkg::in_item_t in_item,
  input  logic              take,
  output logic              avail,
  output md5_pkg::in_item_t head
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  md5_pkg::in_item_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          keep;
  logic          do_push;
  logic          do_pop;

  // the unused command code never enters the queue
  assign keep    = in_item.command != md5_pkg::CMD_NONE;
  assign full    = count == (AW + 1)'(DEPTH);
  assign avail   = count != '0;
  assign do_push = push && !full && keep;
  assign do_pop  = take && avail;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW + 1)'(DEPTH)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !do_pop) else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1) else $error("count slip");
`endif
endmodule

### hw/rtl/md5_back.sv
module md5_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               avail,
  input  md5_pkg::in_item_t  head,
  output logic               take,
  output logic               empty,
  input  logic               pop,
  output md5_pkg::out_item_t out_item
);
  md5_pkg::state_t state, state_next;

  // block buffer as sixteen little-endian words, filled a byte at a time
  logic [31:0] blk [16];
  logic [31:0] h [4];
  logic [31:0] a, b, c, d;
  logic [5:0]  fill;
  logic [60:0] msg_bytes;
  logic        finished;
  logic [5:0]  rnd;
  logic        padding;
  logic        extra;

  logic [31:0] f, sum, rot, w;
  logic [3:0]  g;
  logic [4:0]  sh;
  logic [63:0] bits;
  logic [7:0]  pad_byte;
  logic        is_absorb, is_finish, is_restart;

  assign is_absorb  = head.command == md5_pkg::CMD_ABSORB;
  assign is_finish  = head.command == md5_pkg::CMD_FINISH;
  assign is_restart = head.command == md5_pkg::CMD_RESTART;
  assign bits       = {msg_bytes, 3'b000};

  always_comb begin
    pad_byte = 8'h00;
    if (!padding) begin
      pad_byte = 8'h80;
    end else if (fill >= 6'd56 && !extra) begin
      pad_byte = bits[8 * fill[2:0] +: 8];
    end
  end

  always_comb begin
    unique case (rnd[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    g   = md5_pkg::word_sel(rnd);
    sh  = md5_pkg::rot_amt(rnd);
    w   = blk[g];
    sum = a + f + md5_pkg::ROUND_K[rnd] + w;
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      md5_pkg::ST_IDLE: begin
        if (avail) begin
          priority if (is_absorb && !finished && fill == 6'd63) begin
            state_next = md5_pkg::ST_ROUND;
          end else if (is_finish && !finished) begin
            state_next = md5_pkg::ST_PAD;
          end else if (is_finish) begin
            state_next = md5_pkg::ST_OUT0;
          end
        end
      end
      md5_pkg::ST_PAD: begin
        if (fill == 6'd63) begin
          state_next = md5_pkg::ST_ROUND;
        end
      end
      md5_pkg::ST_ROUND: begin
        if (rnd == 6'd63) begin
          priority if (padding && extra) begin
            state_next = md5_pkg::ST_PAD;
          end else if (padding) begin
            state_next = md5_pkg::ST_OUT0;
          end else begin
            state_next = md5_pkg::ST_IDLE;
          end
        end
      end
      md5_pkg::ST_OUT0: if (pop) state_next = md5_pkg::ST_OUT1;
      md5_pkg::ST_OUT1: if (pop) state_next = md5_pkg::ST_IDLE;
      default: state_next = md5_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    take = (state == md5_pkg::ST_IDLE) && avail;
    empty = !(state == md5_pkg::ST_OUT0 || state == md5_pkg::ST_OUT1);
    out_item.part_index = state == md5_pkg::ST_OUT1;
    out_item.last       = state == md5_pkg::ST_OUT1;
    out_item.digest_part = (state == md5_pkg::ST_OUT1) ? md5_pkg::swap_bytes(h[2], h[3])
                                                       : md5_pkg::swap_bytes(h[0], h[1]);
  end

  always_ff @(posedge clk) begin
    if (state == md5_pkg::ST_IDLE && avail && is_absorb && !finished) begin
      blk[fill[5:2]][8 * fill[1:0] +: 8] <= head.data_byte;
    end else if (state == md5_pkg::ST_PAD) begin
      blk[fill[5:2]][8 * fill[1:0] +: 8] <= pad_byte;
    end
    if (state == md5_pkg::ST_ROUND) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b + rot;
    end else begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= md5_pkg::ST_IDLE;
      h[0]      <= md5_pkg::IV_A;
      h[1]      <= md5_pkg::IV_B;
      h[2]      <= md5_pkg::IV_C;
      h[3]      <= md5_pkg::IV_D;
      fill      <= '0;
      msg_bytes <= '0;
      finished  <= 1'b0;
      rnd       <= '0;
      padding   <= 1'b0;
      extra     <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        md5_pkg::ST_IDLE: begin
          if (avail) begin
            if (is_restart) begin
              h[0]      <= md5_pkg::IV_A;
              h[1]      <= md5_pkg::IV_B;
              h[2]      <= md5_pkg::IV_C;
              h[3]      <= md5_pkg::IV_D;
              fill      <= '0;
              msg_bytes <= '0;
              finished  <= 1'b0;
              padding   <= 1'b0;
              extra     <= 1'b0;
            end else if (is_absorb && !finished) begin
              fill      <= fill + 1'b1;
              msg_bytes <= msg_bytes + 1'b1;
            end
          end
          rnd <= '0;
        end
        md5_pkg::ST_PAD: begin
          // no room left for the length after the 0x80 byte
          if (!padding) begin
            extra <= fill >= 6'd56;
          end
          fill    <= fill + 1'b1;
          padding <= 1'b1;
          rnd     <= '0;
        end
        md5_pkg::ST_ROUND: begin
          rnd <= rnd + 1'b1;
          if (rnd == 6'd63) begin
            h[0] <= h[0] + d;
            h[1] <= h[1] + b + rot;
            h[2] <= h[2] + b;
            h[3] <= h[3] + c;
            // the block that carried the length closes the message
            if (padding) begin
              if (extra) begin
                extra <= 1'b0;
              end else begin
                finished <= 1'b1;
                padding  <= 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    take |-> state == md5_pkg::ST_IDLE) else $error("take outside idle");
  a_out_order: assert property (@(posedge clk) disable iff (rst)
    (state == md5_pkg::ST_OUT0 && pop) |=> state == md5_pkg::ST_OUT1)
    else $error("digest part order");
  a_out_done: assert property (@(posedge clk) disable iff (rst)
    (state == md5_pkg::ST_OUT0) |-> finished) else $error("digest before finish");
`endif
endmodule

### hw/rtl/md5_message_digest.sv
// channel  | handshake     | payload
// input    | push / full   | in_item  (command, data_byte)
// result   | empty / pop   | out_item (digest_part, part_index, last)
// absorb stores one byte, and runs the rounds when it fills a block
// finish pads one byte a cycle, hashes each padded block, then gives two parts
// the single round unit in the back end sets the rate
// a four-entry queue lets the front take items while the rounds run
// rst is synchronous and returns the chaining words to the initial values
module md5_message_digest #(
  parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  md5_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output md5_pkg::out_item_t out_item
);
  logic              take;
  logic              avail;
  md5_pkg::in_item_t head;

  md5_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst, .push, .full, .in_item, .take, .avail, .head
  );

  md5_back u_back (
    .clk, .rst, .avail, .head, .take, .empty, .pop, .out_item
  );
endmodule
